@@ sv/pcc_pkg.sv @@
`default_nettype none

package pcc_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [2:0] {
    CMD_INC     = 3'd0,
    CMD_DEC     = 3'd1,
    CMD_CLR     = 3'd2,
    CMD_SET_TGT = 3'd3,
    CMD_TICK    = 3'd4,
    CMD_LOAD    = 3'd5,
    CMD_SAVE    = 3'd6
  } cmd_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAVE_DELAY  = 1'd0,
    CFG_COUNT_LIMIT = 1'd1
  } cfg_idx_t;

  localparam logic [15:0] SAVE_DELAY_RST  = 16'd5000;
  localparam logic [15:0] COUNT_LIMIT_RST = 16'd999;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  localparam logic [31:0] REC_MAGIC = 32'h5354_4348;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  // One accepted command with its operands.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] target_value;
    logic [31:0] rec_magic;
    logic [31:0] rec_count;
    logic [31:0] rec_target;
    logic [31:0] rec_crc;
  } cmd_item_t;

  // State snapshot after one command, plus its event flags.
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] target;
    logic        dirty;
    logic        save;
    logic        load_ok;
  } res_item_t;

  typedef logic [31:0][31:0] crc_cols_t;

  // Advance a reflected CRC-32 register by 32 zero bits (linear map).
  function automatic logic [31:0] crc_adv(input logic [31:0] crc);
    logic [31:0] x;
    x = crc;
    for (int b = 0; b < 32; b++) begin
      x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    end
    return x;
  endfunction

  // Contribution of the initial value and the magic word.
  function automatic logic [31:0] crc_const();
    return ~crc_adv(crc_adv(crc_adv(CRC_INIT ^ REC_MAGIC)));
  endfunction

  // Column j: effect of bit j of a word followed by the given number of advances.
  function automatic crc_cols_t crc_cols(input int unsigned steps);
    crc_cols_t   cols;
    logic [31:0] x;
    for (int j = 0; j < 32; j++) begin
      x = 32'd1 << j;
      for (int s = 0; s < 3; s++) begin
        if (s < steps) begin
          x = crc_adv(x);
        end
      end
      cols[j] = x;
    end
    return cols;
  endfunction

endpackage

`default_nettype wire

@@ sv/pcc_crc32.sv @@
`default_nettype none

// Record CRC over magic, count word and target word as a fixed XOR tree.
module pcc_crc32 (
  input  wire logic [31:0] word_count,
  input  wire logic [31:0] word_target,
  output logic      [31:0] crc
);

  localparam logic [31:0]             CRC_K  = pcc_pkg::crc_const();
  localparam pcc_pkg::crc_cols_t      COLS_C = pcc_pkg::crc_cols(2);
  localparam pcc_pkg::crc_cols_t      COLS_T = pcc_pkg::crc_cols(1);

  always_comb begin
    crc = CRC_K;
    for (int j = 0; j < 32; j++) begin
      if (word_count[j]) begin
        crc = crc ^ COLS_C[j];
      end
      if (word_target[j]) begin
        crc = crc ^ COLS_T[j];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/pcc_state.sv @@
`default_nettype none

// Counter state and per-command update; registers one result per transfer.
module pcc_state (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [15:0]        save_delay,
  input  wire logic [15:0]        count_limit,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire pcc_pkg::cmd_item_t cmd_item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output pcc_pkg::res_item_t      res_item
);

  logic [15:0]        count_r, count_nxt;
  logic [15:0]        target_r, target_nxt;
  logic               dirty_r, dirty_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic               res_valid_r;
  pcc_pkg::res_item_t res_r, res_nxt;

  logic [31:0] load_crc;
  logic        load_match;
  logic        do_save;
  logic [31:0] limit_w;
  logic        advance;

  pcc_crc32 u_load_crc (
    .word_count  (cmd_item.rec_count),
    .word_target (cmd_item.rec_target),
    .crc         (load_crc)
  );

  assign limit_w    = {16'd0, count_limit};
  assign load_match = (cmd_item.rec_magic == pcc_pkg::REC_MAGIC) &&
                      (load_crc == cmd_item.rec_crc);
  assign cmd_ready  = !res_valid_r || res_ready;
  assign advance    = cmd_valid && cmd_ready;

  always_comb begin
    count_nxt   = count_r;
    target_nxt  = target_r;
    dirty_nxt   = dirty_r;
    elapsed_nxt = elapsed_r;
    do_save     = 1'b0;
    res_nxt     = '0;
    case (cmd_item.cmd)
      pcc_pkg::CMD_INC: begin
        if (count_r < count_limit) begin
          count_nxt   = count_r + 16'd1;
          dirty_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
      end
      pcc_pkg::CMD_DEC: begin
        if (count_r != 16'd0) begin
          count_nxt   = count_r - 16'd1;
          dirty_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
      end
      pcc_pkg::CMD_CLR: begin
        count_nxt   = '0;
        dirty_nxt   = 1'b1;
        elapsed_nxt = '0;
      end
      pcc_pkg::CMD_SET_TGT: begin
        target_nxt  = (cmd_item.target_value > limit_w) ? count_limit
                                                        : cmd_item.target_value[15:0];
        dirty_nxt   = 1'b1;
        elapsed_nxt = '0;
      end
      pcc_pkg::CMD_TICK: begin
        if (dirty_r) begin
          if (elapsed_r != pcc_pkg::ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
          do_save = (elapsed_nxt >= save_delay);
        end
      end
      pcc_pkg::CMD_LOAD: begin
        if (load_match) begin
          count_nxt  = (cmd_item.rec_count > limit_w) ? count_limit
                                                      : cmd_item.rec_count[15:0];
          target_nxt = (cmd_item.rec_target > limit_w) ? count_limit
                                                       : cmd_item.rec_target[15:0];
        end else begin
          count_nxt  = '0;
          target_nxt = '0;
        end
        dirty_nxt   = 1'b0;
        elapsed_nxt = '0;
      end
      pcc_pkg::CMD_SAVE: begin
        do_save = 1'b1;
      end
      default: begin
      end
    endcase
    if (do_save) begin
      dirty_nxt   = 1'b0;
      elapsed_nxt = '0;
    end
    res_nxt.count   = count_nxt;
    res_nxt.target  = target_nxt;
    res_nxt.dirty   = dirty_nxt;
    res_nxt.save    = do_save;
    res_nxt.load_ok = (cmd_item.cmd == pcc_pkg::CMD_LOAD) && load_match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      target_r    <= '0;
      dirty_r     <= 1'b0;
      elapsed_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        count_r   <= count_nxt;
        target_r  <= target_nxt;
        dirty_r   <= dirty_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (cmd_ready) begin
        res_valid_r <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_item  = res_r;

endmodule

`default_nettype wire

@@ sv/pcc_out.sv @@
`default_nettype none

// Save CRC over the committed values and the output register.
module pcc_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  output logic                   res_ready,
  input  wire pcc_pkg::res_item_t res_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            out_count_now,
  output logic [15:0]            out_target_now,
  output logic                   out_dirty_now,
  output logic                   out_save_strobe,
  output logic [31:0]            out_save_crc,
  output logic                   out_load_ok
);

  logic        out_valid_r;
  logic [15:0] count_r, target_r;
  logic        dirty_r, save_r, load_ok_r;
  logic [31:0] crc_r;
  logic [31:0] save_crc;

  pcc_crc32 u_save_crc (
    .word_count  ({16'd0, res_item.count}),
    .word_target ({16'd0, res_item.target}),
    .crc         (save_crc)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      count_r   <= res_item.count;
      target_r  <= res_item.target;
      dirty_r   <= res_item.dirty;
      save_r    <= res_item.save;
      load_ok_r <= res_item.load_ok;
      crc_r     <= res_item.save ? save_crc : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count_now   = count_r;
  assign out_target_now  = target_r;
  assign out_dirty_now   = dirty_r;
  assign out_save_strobe = save_r;
  assign out_save_crc    = crc_r;
  assign out_load_ok     = load_ok_r;

endmodule

`default_nettype wire

@@ sv/persistent_counter_with_crc_commit.sv @@
`default_nettype none

// Persistent up/down counter with a deferred, CRC-protected commit. Each
// input transfer carries one command (increment, decrement, clear, set
// target, millisecond tick, load record, save now) and yields exactly one
// output transfer with the count, target and dirty mark after the command,
// a save strobe with the record's reflected CRC-32 (magic, count, target as
// 32-bit words; zero when no save) and a load-accepted flag. The block is a
// three-stage pipeline: input register, state update, output register with
// the save CRC. It takes one command per clock cycle with both channels
// flowing; a command's result passes the input register, the state register
// and the output register in that order before out_valid rises. The state is
// updated once per command, so each command sees the state left by the one before it.
// Configuration (save delay, count limit) may be written only while the
// block is idle.
module persistent_counter_with_crc_commit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_wdata,
  // command channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_cmd,
  input  wire logic [31:0]                       in_target_value,
  input  wire logic [31:0]                       in_rec_magic,
  input  wire logic [31:0]                       in_rec_count,
  input  wire logic [31:0]                       in_rec_target,
  input  wire logic [31:0]                       in_rec_crc,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [15:0]                            out_count_now,
  output logic [15:0]                            out_target_now,
  output logic                                   out_dirty_now,
  output logic                                   out_save_strobe,
  output logic [31:0]                            out_save_crc,
  output logic                                   out_load_ok
);

  // config registers
  logic [15:0] save_delay_r;
  logic [15:0] count_limit_r;

  // input stage
  logic               s1_valid_r;
  pcc_pkg::cmd_item_t s1_item_r;
  logic               s1_ready;

  // state stage to output stage
  logic               s2_valid;
  logic               s2_ready;
  pcc_pkg::res_item_t s2_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      save_delay_r  <= pcc_pkg::SAVE_DELAY_RST;
      count_limit_r <= pcc_pkg::COUNT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcc_pkg::CFG_SAVE_DELAY:  save_delay_r  <= cfg_wdata;
        pcc_pkg::CFG_COUNT_LIMIT: count_limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register: refills in the same cycle its content moves on.
  assign in_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.cmd          <= in_cmd;
      s1_item_r.target_value <= in_target_value;
      s1_item_r.rec_magic    <= in_rec_magic;
      s1_item_r.rec_count    <= in_rec_count;
      s1_item_r.rec_target   <= in_rec_target;
      s1_item_r.rec_crc      <= in_rec_crc;
    end
  end

  // Count/target/dirty/elapsed live here; load CRC check is in this stage.
  pcc_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .save_delay  (save_delay_r),
    .count_limit (count_limit_r),
    .cmd_valid   (s1_valid_r),
    .cmd_ready   (s1_ready),
    .cmd_item    (s1_item_r),
    .res_valid   (s2_valid),
    .res_ready   (s2_ready),
    .res_item    (s2_item)
  );

  // Save CRC depends only on the committed values, so it sits one stage later.
  pcc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (s2_valid),
    .res_ready       (s2_ready),
    .res_item        (s2_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_count_now   (out_count_now),
    .out_target_now  (out_target_now),
    .out_dirty_now   (out_dirty_now),
    .out_save_strobe (out_save_strobe),
    .out_save_crc    (out_save_crc),
    .out_load_ok     (out_load_ok)
  );

endmodule

`default_nettype wire
